// ===== hw/rtl/smrls_pkg.sv =====
`timescale 1ns / 1ps

package smrls_pkg;

  localparam int DEF_MAX_ROWS     = 16;
  localparam int DEF_MAX_COLS     = 16;
  localparam int DEF_ROW_CAPACITY = 8;
  localparam int DEF_VALUE_WIDTH  = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'd1;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_GET    = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INDEX     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic       latch_req;
    logic       clr_pos;
    logic       inc_pos;
    logic       rd_en;
    logic       rd_next;
    logic       append;
    logic       shift_wr;
    logic       fill_dec;
    logic       load_out;
    logic       take_value;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       idx_ok;
    logic       full;
    logic       fill_zero;
    logic       match;
    logic       last_slot;
    logic       next_last;
  } sts_t;

endpackage

// ===== hw/rtl/sparse_matrix_row_list_store.sv =====
`timescale 1ns / 1ps

// Sparse matrix store that keeps, for each row, a short ordered list of (column, value)
// entries in one slot memory with a single read port and a single write port. One item
// is worked on at a time. An add or a rejected item goes from acceptance straight through
// evaluation to a loaded result, while a get or a remove on a non-empty row also scans it:
// each slot scanned costs a memory read and a compare, and each entry moved during a remove
// costs a read and a write. The output register holds a finished result, so the next
// item can be accepted while the previous result is still waiting to be taken.
module sparse_matrix_row_list_store import smrls_pkg::*; #(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int ROW_CAPACITY = DEF_ROW_CAPACITY,
  parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  cmd_t cmd;
  sts_t sts;

  smrls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smrls_dp #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .ROW_CAPACITY (ROW_CAPACITY),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== hw/rtl/smrls_dp.sv =====
`timescale 1ns / 1ps

module smrls_dp import smrls_pkg::*; #(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int ROW_CAPACITY = DEF_ROW_CAPACITY,
  parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  output out_item_t             out_data_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int NROWS  = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int NCOLS  = (MAX_COLS < 16) ? MAX_COLS : 16;
  localparam int RW     = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int POS_W  = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
  localparam int FILL_W = $clog2(ROW_CAPACITY + 1);
  localparam int SW     = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int DEPTH  = NROWS * (2 ** POS_W);
  localparam int AW     = RW + POS_W;

  typedef struct packed {
    logic [3:0]    col;
    logic [SW-1:0] val;
  } slot_t;

  in_item_t              req_q;
  logic [POS_W-1:0]      pos_q;
  logic [FILL_W-1:0]     fill_q [NROWS];
  logic [CFG_DATA_W-1:0] rows_q;
  logic [CFG_DATA_W-1:0] cols_q;
  slot_t                 rd_q;
  out_item_t             out_q;
  slot_t                 slot_mem [DEPTH];

  logic [RW-1:0]     row_sel;
  logic [FILL_W-1:0] fill_cur;
  logic [FILL_W:0]   pos_ext;
  logic [FILL_W:0]   fill_ext;
  logic [POS_W-1:0]  rd_pos;
  logic [POS_W-1:0]  wr_pos;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  slot_t             wr_data;
  logic              wr_en;

  assign row_sel  = req_q.row_index[RW-1:0];
  assign fill_cur = fill_q[row_sel];
  assign pos_ext  = (FILL_W + 1)'(pos_q);
  assign fill_ext = (FILL_W + 1)'(fill_cur);

  assign sts_o.kind      = req_q.kind;
  assign sts_o.idx_ok    = ({1'b0, req_q.row_index} < rows_q) &&
                           (int'(req_q.row_index) < NROWS) &&
                           ({1'b0, req_q.col_index} < cols_q) &&
                           (int'(req_q.col_index) < NCOLS);
  assign sts_o.full      = (fill_cur >= FILL_W'(ROW_CAPACITY));
  assign sts_o.fill_zero = (fill_cur == '0);
  assign sts_o.match     = (rd_q.col == req_q.col_index);
  assign sts_o.last_slot = ((pos_ext + (FILL_W + 1)'(1)) >= fill_ext);
  assign sts_o.next_last = ((pos_ext + (FILL_W + 1)'(2)) >= fill_ext);

  assign rd_pos  = cmd_i.rd_next ? (pos_q + POS_W'(1)) : pos_q;
  assign wr_pos  = cmd_i.append ? POS_W'(fill_cur) : pos_q;
  assign rd_addr = {row_sel, rd_pos};
  assign wr_addr = {row_sel, wr_pos};
  assign wr_en   = cmd_i.append || cmd_i.shift_wr;
  assign wr_data = cmd_i.append ? slot_t'({req_q.col_index, req_q.elem_value[SW-1:0]}) : rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.clr_pos) begin
      pos_q <= '0;
    end else if (cmd_i.inc_pos) begin
      pos_q <= pos_q + POS_W'(1);
    end
    if (cmd_i.load_out) begin
      out_q.read_value <= cmd_i.take_value ? 32'(signed'(rd_q.val)) : '0;
      out_q.status     <= cmd_i.res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_DATA_W'(16);
      cols_q <= CFG_DATA_W'(16);
      for (int i = 0; i < NROWS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ROWS_IN_USE: rows_q <= cfg_data_i;
          CFG_COLS_IN_USE: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.append) begin
        fill_q[row_sel] <= fill_cur + FILL_W'(1);
      end else if (cmd_i.fill_dec) begin
        fill_q[row_sel] <= fill_cur - FILL_W'(1);
      end
    end
  end

  assign out_data_o = out_q;

  a_append_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (sts_o.idx_ok && !sts_o.full))
    else $error("Entry appended to a full row or at a bad index.");

  a_shift_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> (!sts_o.last_slot && !sts_o.fill_zero))
    else $error("Compaction wrote a slot with no later entry behind it.");

endmodule

// ===== hw/rtl/smrls_ctrl.sv =====
`timescale 1ns / 1ps

module smrls_ctrl import smrls_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] res_status_q, res_status_d;
  logic       res_take_q, res_take_d;
  logic       miss_status_sel;
  logic [1:0] miss_status;

  assign miss_status_sel = (sts_i.kind == KIND_REMOVE);
  assign miss_status     = miss_status_sel ? ST_NOT_FOUND : ST_OK;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_status_d = res_status_q;
    res_take_d   = res_take_q;
    cmd_o        = '0;
    cmd_o.res_status = res_status_q;
    cmd_o.take_value = res_take_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        res_take_d    = 1'b0;
        cmd_o.clr_pos = 1'b1;
        res_status_d  = ST_OK;
        state_d       = S_DONE;
        priority if (sts_i.kind == KIND_NONE) begin
          res_status_d = ST_OK;
        end else if (!sts_i.idx_ok) begin
          res_status_d = ST_INDEX;
        end else if (sts_i.kind == KIND_ADD) begin
          if (sts_i.full) begin
            res_status_d = ST_FULL;
          end else begin
            cmd_o.append = 1'b1;
          end
        end else if (sts_i.fill_zero) begin
          res_status_d = miss_status;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        priority if (sts_i.match && sts_i.kind == KIND_GET) begin
          res_status_d = ST_OK;
          res_take_d   = 1'b1;
          state_d      = S_DONE;
        end else if (sts_i.match && sts_i.last_slot) begin
          res_status_d   = ST_OK;
          cmd_o.fill_dec = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.match) begin
          res_status_d = ST_OK;
          state_d      = S_SHIFT_RD;
        end else if (sts_i.last_slot) begin
          res_status_d = miss_status;
          state_d      = S_DONE;
        end else begin
          cmd_o.inc_pos = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.inc_pos  = 1'b1;
        if (sts_i.next_last) begin
          cmd_o.fill_dec = 1'b1;
          state_d        = S_DONE;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
      res_take_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
      res_take_q   <= res_take_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("Result became valid without finishing an item.");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("Finished item left while the output register was still occupied.");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_WR) |-> $past(state_q == S_SHIFT_RD))
    else $error("Compaction write without the preceding slot read.");

endmodule

// ===== test/sparse_matrix_row_list_store_checker.sv =====
`timescale 1ns / 1ps

module sparse_matrix_row_list_store_checker import smrls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int ROW_SLOTS = DEF_ROW_CAPACITY;
  localparam int ROW_COUNT = DEF_MAX_ROWS;
  localparam int COL_COUNT = DEF_MAX_COLS;

  logic [3:0]  entry_col [ROW_COUNT][ROW_SLOTS];
  logic [31:0] entry_val [ROW_COUNT][ROW_SLOTS];
  int          entry_count [ROW_COUNT];
  int          row_limit;
  int          col_limit;
  out_item_t   answers_due[$];
  out_item_t   due;
  int          fails;

  // Applies one request to the local copy of the matrix and returns its answer.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t res;
    int        r;
    int        c;
    int        fill;
    int        pos;
    res.read_value = '0;
    res.status     = ST_OK;
    r = int'(req.row_index);
    c = int'(req.col_index);
    if (req.kind != KIND_NONE) begin
      if (r >= row_limit || r >= ROW_COUNT || c >= col_limit || c >= COL_COUNT) begin
        res.status = ST_INDEX;
      end else begin
        fill = entry_count[r];
        pos  = fill;
        for (int i = fill - 1; i >= 0; i--) begin
          if (int'(entry_col[r][i]) == c) pos = i;
        end
        if (req.kind == KIND_ADD) begin
          if (fill >= ROW_SLOTS) begin
            res.status = ST_FULL;
          end else begin
            entry_col[r][fill] = 4'(c);
            entry_val[r][fill] = req.elem_value;
            entry_count[r]     = fill + 1;
          end
        end else if (req.kind == KIND_REMOVE) begin
          if (pos >= fill) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < fill; i++) begin
              entry_col[r][i] = entry_col[r][i+1];
              entry_val[r][i] = entry_val[r][i+1];
            end
            entry_count[r] = fill - 1;
          end
        end else if (pos < fill) begin
          res.read_value = entry_val[r][pos];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_limit = ROW_COUNT;
      col_limit = COL_COUNT;
      foreach (entry_count[i]) entry_count[i] = 0;
      answers_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ROWS_IN_USE) row_limit = int'(cfg_data_i);
        else if (cfg_index_i == CFG_COLS_IN_USE) col_limit = int'(cfg_data_i);
      end
      if (in_valid_i && !in_stall_i) answers_due.push_back(apply_request(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("[%0t] unexpected result: read_value %0d status %0d", $realtime,
                     $signed(out_data_i.read_value), out_data_i.status);
          end
        end else begin
          due = answers_due.pop_front();
          if (out_data_i.read_value !== due.read_value || out_data_i.status !== due.status)
          begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] mismatch: expected read_value %0d status %0d, got %0d / %0d",
                       $realtime, $signed(due.read_value), due.status,
                       $signed(out_data_i.read_value), out_data_i.status);
            end
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= answers_due.size();
    end
  end

endmodule

// ===== test/sparse_matrix_row_list_store_tb.sv =====
`timescale 1ns / 1ps

module sparse_matrix_row_list_store_tb;
  import smrls_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 150;
  localparam int SETTLE     = 2 * DEF_ROW_CAPACITY + 6;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;

  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   rows_now;
  int   cols_now;
  logic calm;
  logic hold_req;
  bit   hold_done;

  sparse_matrix_row_list_store dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  sparse_matrix_row_list_store_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure: random bursts, one long hold-off on request.
  initial begin
    out_stall_i <= 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0, 1: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clk_i);
          end
          5: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(30, 60)) @(posedge clk_i);
          end
          default: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk_i);
          end
        endcase
      end
    end
  end

  task automatic push_item(input in_item_t req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_request(input logic [1:0] kind, input int row, input int col,
                              input logic [31:0] value);
    in_item_t req;
    req.kind       = kind;
    req.row_index  = 4'(row);
    req.col_index  = 4'(col);
    req.elem_value = value;
    push_item(req);
  endtask

  task automatic send_random();
    in_item_t req;
    int       rows_eff;
    int       cols_eff;
    int       pick;
    rows_eff = (rows_now > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_now;
    cols_eff = (cols_now > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_now;
    pick = $urandom_range(0, 99);
    if (pick < 42) req.kind = KIND_ADD;
    else if (pick < 70) req.kind = KIND_REMOVE;
    else if (pick < 96) req.kind = KIND_GET;
    else req.kind = KIND_NONE;
    if (rows_eff == 0 || $urandom_range(0, 9) == 0) req.row_index = 4'($urandom_range(0, 15));
    else req.row_index = 4'($urandom_range(0, rows_eff - 1));
    if (cols_eff == 0 || $urandom_range(0, 9) == 0) begin
      req.col_index = 4'($urandom_range(0, 15));
    end else if ($urandom_range(0, 1) == 0) begin
      req.col_index = 4'($urandom_range(0, ((cols_eff < 4) ? cols_eff : 4) - 1));
    end else begin
      req.col_index = 4'($urandom_range(0, cols_eff - 1));
    end
    case ($urandom_range(0, 7))
      0: req.elem_value = 32'h8000_0000;
      1: req.elem_value = 32'h7FFF_FFFF;
      default: req.elem_value = $urandom();
    endcase
    push_item(req);
  endtask

  task automatic wait_all_answered();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_limits(input int rows, input int cols);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROWS_IN_USE;
    cfg_data_i  <= CFG_DATA_W'(rows);
    @(posedge clk_i);
    cfg_index_i <= CFG_COLS_IN_USE;
    cfg_data_i  <= CFG_DATA_W'(cols);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rows_now = rows;
    cols_now = cols;
  endtask

  task automatic run_phase(input int rows, input int cols, input int count,
                           input int hold_at, input bit last);
    wait_all_answered();
    if (last) calm <= 1'b1;
    set_limits(rows, cols);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req <= 1'b1;
      send_random();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_ROWS_IN_USE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    calm        <= 1'b0;
    hold_req    <= 1'b0;
    idle_cycles <= 0;
    rows_now = DEF_MAX_ROWS;
    cols_now = DEF_MAX_COLS;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty row, duplicate columns, and removal of the first match.
    send_request(KIND_GET, 0, 0, 32'h0);
    send_request(KIND_REMOVE, 0, 0, 32'h0);
    send_request(KIND_ADD, 0, 0, 32'h7FFF_FFFF);
    send_request(KIND_ADD, 0, 0, 32'h8000_0000);
    send_request(KIND_GET, 0, 0, 32'hFFFF_FFFF);
    send_request(KIND_REMOVE, 0, 0, 32'h0);
    send_request(KIND_GET, 0, 0, 32'h0);
    send_request(KIND_ADD, 15, 15, 32'hFFFF_FFFF);
    send_request(KIND_GET, 15, 15, 32'h0);
    send_request(KIND_NONE, 15, 15, 32'h1234_5678);
    // Fill the last row, overflow it, then remove from the middle.
    for (int c = 1; c < DEF_ROW_CAPACITY; c++) send_request(KIND_ADD, 15, c, 32'h100 * c);
    send_request(KIND_ADD, 15, 8, 32'h5555_AAAA);
    send_request(KIND_REMOVE, 15, 3, 32'h0);
    send_request(KIND_GET, 15, 7, 32'h0);
    send_request(KIND_GET, 15, 3, 32'h0);
    send_request(KIND_ADD, 15, 14, 32'hAAAA_5555);

    run_phase(16, 16, 250, 100, 1'b0);
    run_phase(1, 16, 80, -1, 1'b0);
    run_phase(16, 1, 80, -1, 1'b0);
    run_phase(0, 16, 30, -1, 1'b0);
    run_phase(31, 31, 150, -1, 1'b0);
    run_phase(5, 9, 150, -1, 1'b0);
    run_phase(12, 3, 150, -1, 1'b0);
    run_phase(16, 16, 180, -1, 1'b1);

    wait_all_answered();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sparse_matrix_row_list_store.f =====
hw/rtl/smrls_pkg.sv
hw/rtl/smrls_dp.sv
hw/rtl/smrls_ctrl.sv
hw/rtl/sparse_matrix_row_list_store.sv
test/sparse_matrix_row_list_store_checker.sv
test/sparse_matrix_row_list_store_tb.sv
